[hw/rtl/yuv_pkg.sv]
package yuv_pkg;

  localparam int WORD_W  = 32;
  localparam int PIX_W   = 16;
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd800;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [DIM_W-1:0] DIM_MAX      = 12'd2048;
  localparam logic [DIM_W-1:0] WIDTH_MIN    = 12'd2;
  localparam logic [DIM_W-1:0] HEIGHT_MIN   = 12'd1;

  // Q16 sums stay within +/-2^25
  localparam int SUM_W = 27;
  localparam int FRAC_W = 16;

  localparam logic signed [SUM_W-1:0] COEF_RV = 27'sd89830;
  localparam logic signed [SUM_W-1:0] COEF_GV = 27'sd45744;
  localparam logic signed [SUM_W-1:0] COEF_GU = 27'sd22127;
  localparam logic signed [SUM_W-1:0] COEF_BU = 27'sd113537;

  localparam logic signed [SUM_W-FRAC_W-1:0] CHAN_MAX = 11'sd255;

  // floor of q / 2^16, saturated to 0..255
  function automatic logic [7:0] chan_clamp(input logic signed [SUM_W-1:0] q);
    logic signed [SUM_W-FRAC_W-1:0] f;
    f = $signed(q[SUM_W-1:FRAC_W]);
    if (f < 0) begin
      chan_clamp = 8'd0;
    end else if (f > CHAN_MAX) begin
      chan_clamp = 8'd255;
    end else begin
      chan_clamp = f[7:0];
    end
  endfunction

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] e;
    e = {w[DIM_W-1:1], 1'b0};
    if (e == '0) begin
      e = WIDTH_MIN;
    end else if (e > DIM_MAX) begin
      e = DIM_MAX;
    end
    eff_width = e;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
    logic [DIM_W-1:0] e;
    e = h;
    if (e == '0) begin
      e = HEIGHT_MIN;
    end else if (e > DIM_MAX) begin
      e = DIM_MAX;
    end
    eff_height = e;
  endfunction

endpackage

[hw/rtl/yuv_if.sv]
interface yuv_in_if import yuv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] macro_word;

  modport source (output valid, output macro_word, input ready);
  modport sink (input valid, input macro_word, output ready);
endinterface

interface yuv_out_if import yuv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_first;
  logic [PIX_W-1:0]   pixel_second;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               frame_last;

  modport source (output valid, output pixel_first, output pixel_second, output column,
                  output row, output frame_last, input ready);
  modport sink (input valid, input pixel_first, input pixel_second, input column,
                input row, input frame_last, output ready);
endinterface

interface yuv_cfg_if import yuv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/yuv422_to_rgb565_converter.sv]
// a macropixel accepted into the input register moves on to the result register once that register is free
// throughput: one macropixel per clock while out_ready is high, set by the input and result registers
// ready follows the result register: in_ready stays high while out_ready is high
// reset (rst_n low, synchronous) empties both stages, zeroes the column and
// row counters and loads a frame of 800 x 480
module yuv422_to_rgb565_converter import yuv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  yuv_in_if.sink     in_if,
  yuv_out_if.source  out_if,
  yuv_cfg_if.sink    cfg_if
);

  logic [DIM_W-1:0]   width_eff_r, height_eff_r;
  logic [COORD_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [COORD_W-1:0] row_cnt_r, row_cnt_nxt;

  logic               s1_valid_r;
  logic [WORD_W-1:0]  s1_word_r;
  logic [COORD_W-1:0] s1_col_r, s1_row_r;
  logic               s1_last_r;

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pix0_r, out_pix1_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;
  logic               out_last_r;

  logic [PIX_W-1:0]   pix0, pix1;
  logic [DIM_W-1:0]   col_sum, row_sum;
  logic               row_end, frame_end;
  logic               in_acc, out_load, cfg_acc;

  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_eff_r  <= WIDTH_RESET;
      height_eff_r <= HEIGHT_RESET;
    end else if (cfg_acc) begin
      case (cfg_if.index)
        CFG_FRAME_WIDTH:  width_eff_r  <= eff_width(cfg_if.data);
        CFG_FRAME_HEIGHT: height_eff_r <= eff_height(cfg_if.data);
        default: ;
      endcase
    end
  end

  assign out_load    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || out_load;
  assign in_acc      = in_if.valid && in_if.ready;

  // frame position, taken when the transaction is accepted
  assign col_sum   = {1'b0, col_cnt_r} + DIM_W'(2);
  assign row_sum   = {1'b0, row_cnt_r} + DIM_W'(1);
  assign row_end   = col_sum >= width_eff_r;
  assign frame_end = row_end && (row_sum >= height_eff_r);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = frame_end ? '0 : row_sum[COORD_W-1:0];
      end else begin
        col_cnt_nxt = col_sum[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (!out_valid_r || out_if.ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_word_r <= in_if.macro_word;
      s1_col_r  <= col_cnt_r;
      s1_row_r  <= row_cnt_r;
      s1_last_r <= frame_end;
    end
    if (out_load) begin
      out_pix0_r <= pix0;
      out_pix1_r <= pix1;
      out_col_r  <= s1_col_r;
      out_row_r  <= s1_row_r;
      out_last_r <= s1_last_r;
    end
  end

  yuv_pix u_pix (
    .macro_word   (s1_word_r),
    .pixel_first  (pix0),
    .pixel_second (pix1)
  );

  assign out_if.valid        = out_valid_r;
  assign out_if.pixel_first  = out_pix0_r;
  assign out_if.pixel_second = out_pix1_r;
  assign out_if.column       = out_col_r;
  assign out_if.row          = out_row_r;
  assign out_if.frame_last   = out_last_r;

  a_col_even: assert property (@(posedge clk) disable iff (!rst_n)
    !col_cnt_r[0])
    else $error("column counter is odd");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    !width_eff_r[0] && width_eff_r >= WIDTH_MIN && width_eff_r <= DIM_MAX)
    else $error("effective width out of range");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (col_cnt_r == '0 && row_cnt_r == '0))
    else $error("counters did not wrap at end of frame");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(s1_word_r)))
    else $error("stalled transaction lost in input stage");

endmodule

[hw/rtl/yuv_pix.sv]
module yuv_pix import yuv_pkg::*; (
  input  logic [WORD_W-1:0] macro_word,
  output logic [PIX_W-1:0]  pixel_first,
  output logic [PIX_W-1:0]  pixel_second
);

  logic [7:0] y0, y1, u, v;
  logic signed [7:0] du, dv;
  logic signed [SUM_W-1:0] rv, gv, gu, bu;

  assign y0 = macro_word[7:0];
  assign u  = macro_word[15:8];
  assign y1 = macro_word[23:16];
  assign v  = macro_word[31:24];

  // x - 128 on a byte is the byte with its top bit flipped, read as signed
  assign du = $signed({~u[7], u[6:0]});
  assign dv = $signed({~v[7], v[6:0]});

  // chroma terms are shared by both pixels
  assign rv = COEF_RV * SUM_W'(dv);
  assign gv = COEF_GV * SUM_W'(dv);
  assign gu = COEF_GU * SUM_W'(du);
  assign bu = COEF_BU * SUM_W'(du);

  function automatic logic [PIX_W-1:0] pack565(input logic [7:0] y,
                                               input logic signed [SUM_W-1:0] rv_t,
                                               input logic signed [SUM_W-1:0] gv_t,
                                               input logic signed [SUM_W-1:0] gu_t,
                                               input logic signed [SUM_W-1:0] bu_t);
    logic signed [SUM_W-1:0] ys;
    logic [7:0] r, g, b;
    ys = $signed({3'b000, y, 16'h0000});
    r = chan_clamp(ys + rv_t);
    g = chan_clamp(ys - gv_t - gu_t);
    b = chan_clamp(ys + bu_t);
    pack565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

  assign pixel_first  = pack565(y0, rv, gv, gu, bu);
  assign pixel_second = pack565(y1, rv, gv, gu, bu);

endmodule
